>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the lux reporter.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/alkf_pkg.sv
// Package of the lux reporter: payload and control word types, constant tables.
// No dependencies; used by every module of the block but alkf_div.
package alkf_pkg;

	typedef struct packed {
		logic [7:0] adc_high;
		logic [7:0] adc_low;
	} sample_t;

	typedef struct packed {
		logic [15:0] lux_value;
		logic [15:0] bus_float;
		logic        send_now;
	} report_t;

	// Divider operand selection
	localparam logic [1:0] DSEL_T1   = 2'd0;
	localparam logic [1:0] DSEL_T2   = 2'd1;
	localparam logic [1:0] DSEL_STEP = 2'd2;

	typedef struct packed {
		logic       load_in;
		logic       div_start;
		logic [1:0] div_sel;
		logic       cap_t1;
		logic       cap_t2;
		logic       cap_step;
		logic       load_lux;
		logic       norm_shift;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic mant_big;
		logic out_free;
	} sts_t;

	localparam logic [7:0] BREAKPOINTS [0:14] = '{
		8'd0, 8'd9, 8'd17, 8'd27, 8'd40, 8'd53, 8'd66, 8'd79,
		8'd88, 8'd96, 8'd101, 8'd106, 8'd109, 8'd112, 8'd255
	};
	localparam logic [6:0] DIVISORS [0:4] = '{7'd100, 7'd20, 7'd10, 7'd5, 7'd3};

	localparam logic [7:0]  SAT_HIGH  = 8'h70;
	localparam logic [15:0] EXP_START = 16'h3800;
	localparam logic [15:0] EXP_STEP  = 16'h0800;
	localparam logic [15:0] MANT_MAX  = 16'h07FF;
	localparam logic [15:0] LUX_SAT   = 16'hFFFF;

endpackage

>>> rtl/alkf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the interpolation terms and the change step; no package use.
module alkf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [6:0]  divisor,
	output logic        busy,
	output logic        done,
	output logic [15:0] quotient
);
	logic [15:0] quo_q;
	logic [6:0]  rem_q;
	logic [6:0]  dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [7:0]  trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 7'd0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, keep the partial remainder below the divisor
			rem_q <= fits ? 7'(trial - {1'b0, dvs_q}) : trial[6:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> rtl/alkf_dp.sv
// Datapath of the lux reporter: segment lookup, interpolation, float encoding,
// change test and output register. Uses alkf_pkg, alkf_div and assert_macros.svh.
`include "assert_macros.svh"
module alkf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  alkf_pkg::cmd_t    cmd,
	output alkf_pkg::sts_t    sts,
	input  alkf_pkg::sample_t sample,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_mode,
	output logic              report_valid,
	input  logic              report_stall,
	output alkf_pkg::report_t report
);
	import alkf_pkg::*;

	logic [7:0]  hi_q, lo_q;
	logic [3:0]  seg_q;
	logic        sat_q;
	logic [15:0] q1_q, q2_q, step_q;
	logic [15:0] lux_q, mant_q, expo_q;
	logic [15:0] last_q;
	logic [2:0]  mode_q;
	logic        out_valid_q;
	report_t     out_q;

	logic [3:0]  seg_c;
	logic [7:0]  bp_lo, bp_hi, delta, rest;
	logic [3:0]  sh1;
	logic [4:0]  sh2;
	logic [15:0] t1_num, t2_num;
	logic [15:0] div_dividend;
	logic [6:0]  div_divisor;
	logic [2:0]  mode_sat;
	logic        div_busy, div_done;
	logic [15:0] div_quo;
	logic [16:0] base, term1, term2;
	logic [17:0] lux_sum;
	logic [15:0] lux_c;
	logic [16:0] mant_c;
	logic [15:0] step_eff, diff;
	logic        send_c;
	logic        out_free;

	// segment number: one plus the inner breakpoints (1 to 13) at or below the high byte
	always_comb begin
		seg_c = 4'd1;
		for (int k = 1; k < 14; k++) begin
			if (sample.adc_high >= BREAKPOINTS[k])
				seg_c = seg_c + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			hi_q  <= sample.adc_high;
			lo_q  <= sample.adc_low;
			seg_q <= seg_c;
			sat_q <= sample.adc_high >= SAT_HIGH;
		end
	end

	assign bp_lo  = BREAKPOINTS[seg_q - 4'd1];
	assign bp_hi  = BREAKPOINTS[seg_q];
	assign delta  = bp_hi - bp_lo;
	assign rest   = hi_q - bp_lo;
	assign sh1    = (seg_q < 4'd11) ? seg_q + 4'd2 : seg_q - 4'd2;
	assign sh2    = {1'b0, seg_q} + 5'd2;
	assign t1_num = {8'd0, rest} << sh1;
	assign t2_num = {8'd0, lo_q} << sh2;

	assign mode_sat = (mode_q > 3'd4) ? 3'd4 : mode_q;

	always_comb begin
		case (cmd.div_sel)
			DSEL_T1: begin
				div_dividend = t1_num;
				div_divisor  = delta[6:0];
			end
			DSEL_T2: begin
				div_dividend = t2_num;
				div_divisor  = delta[6:0];
			end
			DSEL_STEP: begin
				div_dividend = last_q;
				div_divisor  = DIVISORS[mode_sat];
			end
			default: begin
				div_dividend = last_q;
				div_divisor  = DIVISORS[mode_sat];
			end
		endcase
	end

	alkf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_t1)
			q1_q <= div_quo;
		if (cmd.cap_t2)
			q2_q <= div_quo;
		if (cmd.cap_step)
			step_q <= div_quo;
	end

	// interpolated lux: segment base plus high and low byte terms
	assign base    = (seg_q > 4'd1) ? (17'd8 << (seg_q - 4'd1)) : 17'd0;
	assign term1   = (seg_q < 4'd11) ? {1'b0, q1_q} : ({1'b0, q1_q} << 4);
	assign term2   = (seg_q < 4'd7) ? {9'd0, q2_q[15:8]} : 17'd0;
	assign lux_sum = {1'b0, base} + {1'b0, term1} + {1'b0, term2};
	assign lux_c   = (sat_q || lux_sum > {2'b00, LUX_SAT}) ? LUX_SAT : lux_sum[15:0];
	assign mant_c  = {2'b00, lux_c[15:1]} + {3'b000, lux_c[15:2]} + {6'd0, lux_c[15:5]};

	always_ff @(posedge clk) begin
		if (cmd.load_lux) begin
			lux_q  <= lux_c;
			mant_q <= mant_c[15:0];
			expo_q <= EXP_START;
		end else if (cmd.norm_shift) begin
			mant_q <= {1'b0, mant_q[15:1]};
			expo_q <= expo_q + EXP_STEP;
		end
	end

	assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;
	assign diff     = (lux_q > last_q) ? lux_q - last_q : last_q - lux_q;
	assign send_c   = (mode_q != 3'd0) && (diff >= step_eff) && (diff != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd0;
			last_q <= 16'd0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_mode;
			if (cmd.load_out && send_c)
				last_q <= lux_q;
		end
	end

	assign out_free = !out_valid_q || !report_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!report_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.lux_value <= lux_q;
			out_q.bus_float <= mant_q + expo_q;
			out_q.send_now  <= send_c;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.mant_big  = mant_q > MANT_MAX;
	assign sts.out_free  = out_free;
	assign report_valid  = out_valid_q;
	assign report        = out_q;

	`ASSERT_NEVER(a_div_restart, cmd.div_start && div_busy, "divider restarted while busy")
	`ASSERT_CLK(a_out_free, cmd.load_out |-> out_free, "output word overwritten while stalled")
	`ASSERT_CLK(a_mant_norm, cmd.load_out |-> mant_q <= MANT_MAX, "mantissa not normalised")
	`ASSERT_CLK(a_out_rise, $rose(out_valid_q) |-> $past(cmd.load_out), "output valid without load")
endmodule

>>> rtl/alkf_ctrl.sv
// Controller of the lux reporter: sequences the input load, the three divisions, the lux
// load, the float normalisation and the output load. Uses alkf_pkg.
module alkf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_stall,
	input  alkf_pkg::sts_t sts,
	output alkf_pkg::cmd_t cmd
);
	import alkf_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_D1GO = 4'd1;
	localparam logic [3:0] S_D1WT = 4'd2;
	localparam logic [3:0] S_D2GO = 4'd3;
	localparam logic [3:0] S_D2WT = 4'd4;
	localparam logic [3:0] S_LUX  = 4'd5;
	localparam logic [3:0] S_D3GO = 4'd6;
	localparam logic [3:0] S_D3WT = 4'd7;
	localparam logic [3:0] S_NORM = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_D1GO;
				end
			end
			S_D1GO: begin
				cmd.div_sel   = DSEL_T1;
				cmd.div_start = 1'b1;
				state_d       = S_D1WT;
			end
			S_D1WT: begin
				cmd.div_sel = DSEL_T1;
				if (sts.div_done) begin
					cmd.cap_t1 = 1'b1;
					state_d    = S_D2GO;
				end
			end
			S_D2GO: begin
				cmd.div_sel   = DSEL_T2;
				cmd.div_start = 1'b1;
				state_d       = S_D2WT;
			end
			S_D2WT: begin
				cmd.div_sel = DSEL_T2;
				if (sts.div_done) begin
					cmd.cap_t2 = 1'b1;
					state_d    = S_LUX;
				end
			end
			S_LUX: begin
				cmd.load_lux = 1'b1;
				state_d      = S_D3GO;
			end
			S_D3GO: begin
				cmd.div_sel   = DSEL_STEP;
				cmd.div_start = 1'b1;
				state_d       = S_D3WT;
			end
			S_D3WT: begin
				cmd.div_sel = DSEL_STEP;
				if (sts.div_done) begin
					cmd.cap_step = 1'b1;
					state_d      = S_NORM;
				end
			end
			S_NORM: begin
				// shift the mantissa down one place a cycle until it fits in 11 bits
				if (sts.mant_big)
					cmd.norm_shift = 1'b1;
				else
					state_d = S_OUT;
			end
			S_OUT: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign sample_stall = state_q != S_IDLE;
endmodule

>>> rtl/adc_to_lux_knx_float_reporter_top.sv
// Light-sensor lux reporter: top level joining controller and datapath.
// From sample word accepted to report word valid: three passes of the shared divider
// (start, 16 quotient bits, capture), the lux load, up to 5 normalise shifts and the
// output load; a stalled report word adds its wait. A new sample word is taken only
// in idle, the cycle after the report word is loaded. Reset (arst_n low, async)
// clears the controller, the report valid flag, the stored change_mode and the last
// sent lux value to zero.
module adc_to_lux_knx_float_reporter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  alkf_pkg::sample_t sample,
	output logic              report_valid,
	input  logic              report_stall,
	output alkf_pkg::report_t report,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        change_mode
);
	import alkf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	alkf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	alkf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_mode     (change_mode),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);
endmodule
